[sv/lcgx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcgx_pkg
// Shared types and constants of the chunk keystream cipher.
// ----------------------------------------------------------------------------
package lcgx_pkg;

	localparam int unsigned LENGTH_BYTES = 4;
	localparam int unsigned LEN_SEL_W    = 2;
	localparam int unsigned LCG_W        = 15;
	localparam int unsigned KEY_W        = 8;
	localparam int unsigned POS_W        = 32;
	localparam int unsigned CLEN_W       = 32;
	localparam int unsigned CFG_IDX_W    = 8;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam logic [4:0]  LCG_MUL  = 5'd21;
	localparam logic [2:0]  LCG_ADD  = 3'd7;
	localparam logic [8:0]  KEY_MOD  = 9'd255;

	localparam logic [7:0]  HEADER_LEN_RESET      = 8'd49;
	localparam logic [15:0] FIRST_CHUNK_LEN_RESET = 16'd384;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHUNK_LEN = 8'd1;

	typedef enum logic [2:0] {
		RG_HEADER = 3'd0,
		RG_CHUNK0 = 3'd1,
		RG_LEN1   = 3'd2,
		RG_CHUNK1 = 3'd3,
		RG_LEN2   = 3'd4,
		RG_CHUNK2 = 3'd5,
		RG_END    = 3'd6
	} region_t;

	typedef struct packed {
		logic [7:0] out_byte;
		region_t    region;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

[sv/lcg_xor_chunk_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_xor_chunk_cipher
// Byte-serial keystream cipher over a framed file: header, three chunks and
// two little-endian length fields; chunk bytes are XORed with the key.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | in_valid / in_ready   | data_byte, frame_start
//   output   | out_valid / out_ready | out_byte, region, last_of_frame
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready is held high; a request's result
// passes the input register, then the result register, on its way to the output.
// The parser state updates as the byte moves from the input register into
// the result register; the generator step and mod-255 fold sit in that path.
// A stalled output holds the input register; in_ready stays high while it
// empties in the same cycle. Reset initialises control state only, no sweep.
// ----------------------------------------------------------------------------
module lcg_xor_chunk_cipher
	import lcgx_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  frame_start,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic [2:0]                 region,
	output logic                       last_of_frame,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        start_s1;
	logic        out_valid_q;
	result_t     res_q, res;
	logic [7:0]  header_len_q;
	logic [15:0] first_chunk_len_q;
	logic        advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	lcgx_frame_ctl u_frame_ctl (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.data_byte       (data_s1),
		.frame_start     (start_s1),
		.header_len      (header_len_q),
		.first_chunk_len (first_chunk_len_q),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= frame_start;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_len_q      <= HEADER_LEN_RESET;
			first_chunk_len_q <= FIRST_CHUNK_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEADER_LEN:      header_len_q      <= cfg_data[7:0];
				CFG_FIRST_CHUNK_LEN: first_chunk_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = res_q.out_byte;
	assign region        = res_q.region;
	assign last_of_frame = res_q.last;

endmodule
`default_nettype wire

[sv/lcgx_keystream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcgx_keystream
// One generator step s' = (s*21+7) mod 32768 and key = s' mod 255.
// ----------------------------------------------------------------------------
module lcgx_keystream
	import lcgx_pkg::*;
(
	input  wire logic [LCG_W-1:0] lcg,
	output logic      [LCG_W-1:0] lcg_next,
	output logic      [KEY_W-1:0] key
);

	logic [LCG_W+4:0] prod;
	logic [8:0]       fold;

	always_comb begin
		prod     = (LCG_W+5)'(lcg) * (LCG_W+5)'(LCG_MUL) + (LCG_W+5)'(LCG_ADD);
		lcg_next = prod[LCG_W-1:0];
		// 256 is 1 mod 255: fold the high byte onto the low byte
		fold     = 9'(lcg_next[LCG_W-1:8]) + 9'(lcg_next[7:0]);
		if (fold >= KEY_MOD) begin
			key = KEY_W'(fold - KEY_MOD);
		end else begin
			key = fold[KEY_W-1:0];
		end
	end

endmodule
`default_nettype wire

[sv/lcgx_frame_ctl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcgx_frame_ctl
// Frame parser state, length capture and chunk XOR for one byte per step.
// ----------------------------------------------------------------------------
module lcgx_frame_ctl
	import lcgx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_start,
	input  wire logic [7:0]  header_len,
	input  wire logic [15:0] first_chunk_len,
	output result_t          res
);

	logic [7:0]        seed_q, seed_d;
	logic [LCG_W-1:0]  lcg_q, lcg_d, lcg_next;
	logic [KEY_W-1:0]  key;
	region_t           region_q, region_d, rg_cur, ck_rg;
	logic [POS_W-1:0]  pos_q, pos_d, pos_cur, pos_inc;
	logic [CLEN_W-1:0] clen_q, clen_d, clen_acc, ck_len;
	logic [7:0]        hl;
	logic              enter_ck;

	lcgx_keystream u_keystream (
		.lcg      (lcg_q),
		.lcg_next (lcg_next),
		.key      (key)
	);

	always_comb begin
		rg_cur   = frame_start ? RG_HEADER : region_q;
		pos_cur  = frame_start ? '0 : pos_q;
		pos_inc  = pos_cur + POS_W'(1);
		hl       = (header_len == 8'd0) ? 8'd1 : header_len;
		seed_d   = seed_q;
		lcg_d    = lcg_q;
		region_d = rg_cur;
		pos_d    = pos_cur;
		clen_d   = clen_q;
		clen_acc = clen_q;
		enter_ck = 1'b0;
		ck_rg    = RG_CHUNK0;
		ck_len   = '0;
		res.out_byte = data_byte;
		res.region   = rg_cur;
		res.last     = 1'b0;

		for (int i = 0; i < 4; i++) begin
			if (i < int'(LENGTH_BYTES) && pos_cur[LEN_SEL_W-1:0] == LEN_SEL_W'(i)) begin
				clen_acc[8*i +: 8] = clen_q[8*i +: 8] | data_byte;
			end
		end

		case (rg_cur)
			RG_HEADER: begin
				if (pos_cur == '0) begin
					seed_d = data_byte;
				end
				pos_d = pos_inc;
				if (pos_inc >= POS_W'(hl)) begin
					enter_ck = 1'b1;
					ck_rg    = RG_CHUNK0;
					ck_len   = CLEN_W'(first_chunk_len);
				end
			end
			RG_CHUNK0, RG_CHUNK1, RG_CHUNK2: begin
				lcg_d        = lcg_next;
				res.out_byte = data_byte ^ key;
				pos_d        = pos_inc;
				if (pos_inc >= clen_q) begin
					pos_d = '0;
					case (rg_cur)
						RG_CHUNK0: begin
							region_d = RG_LEN1;
							clen_d   = '0;
						end
						RG_CHUNK1: begin
							region_d = RG_LEN2;
							clen_d   = '0;
						end
						default: begin
							region_d = RG_END;
							res.last = 1'b1;
						end
					endcase
				end
			end
			RG_LEN1, RG_LEN2: begin
				clen_d = clen_acc;
				pos_d  = pos_inc;
				if (pos_inc >= POS_W'(LENGTH_BYTES)) begin
					enter_ck = 1'b1;
					ck_rg    = (rg_cur == RG_LEN1) ? RG_CHUNK1 : RG_CHUNK2;
					ck_len   = clen_acc;
				end
			end
			default: begin
				res.region = RG_END;
				region_d   = RG_END;
			end
		endcase

		if (enter_ck) begin
			pos_d  = '0;
			clen_d = ck_len;
			lcg_d  = LCG_W'(seed_d);
			if (ck_len != '0) begin
				region_d = ck_rg;
			end else begin
				case (ck_rg)
					RG_CHUNK0: begin
						region_d = RG_LEN1;
						clen_d   = '0;
					end
					RG_CHUNK1: begin
						region_d = RG_LEN2;
						clen_d   = '0;
					end
					default: begin
						region_d = RG_END;
						res.last = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			lcg_q    <= '0;
			region_q <= RG_HEADER;
			pos_q    <= '0;
			clen_q   <= '0;
		end else if (step) begin
			seed_q   <= seed_d;
			lcg_q    <= lcg_d;
			region_q <= region_d;
			pos_q    <= pos_d;
			clen_q   <= clen_d;
		end
	end

endmodule
`default_nettype wire
